@@ sv/salm_pkg.sv @@
package salm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int BUF_W = 13;
   localparam int INDEX_W = 4;
   localparam int LEVEL_W = 16;
   localparam int MAG_W = 17;
   localparam int FULL_SCALE = 32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EVAL,
      ST_DIVM_GO,
      ST_DIVM_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic search_step;
      logic eval;
      logic div_start;
      logic div_mean;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic close;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

@@ sv/salm_div.sv @@
module salm_div #(
   parameter int WIDTH = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] dsr_ff;
   logic [WIDTH:0]   trial;
   logic             q_bit;
   logic [WIDTH-1:0] rem_in;

   always_comb begin
      trial = {rem_ff, quo_ff[WIDTH-1]};
      q_bit = trial >= {1'b0, dsr_ff};
      if (q_bit) begin
         rem_in = WIDTH'(trial - {1'b0, dsr_ff});
      end else begin
         rem_in = trial[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(WIDTH);
      end else if (busy_ff) begin
         busy_ff <= cnt_ff != CNT_W'(1);
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[WIDTH-2:0], q_bit};
      end
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/salm_dp.sv @@
module salm_dp #(
   parameter int SEGMENTS = 16,
   parameter int MAX_BUFFER = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  salm_pkg::cmd_type                   cmd,
   output salm_pkg::status_type                status,
   input  logic signed [salm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [salm_pkg::BUF_W-1:0]          req_buffer_samples,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [salm_pkg::INDEX_W-1:0]        rsp_segment_index,
   output logic [salm_pkg::LEVEL_W-1:0]        rsp_level
);

   localparam int LEN_W = $clog2(MAX_BUFFER + 1);
   localparam int POS_W = $clog2(MAX_BUFFER);
   localparam int SEG_W = $clog2(SEGMENTS);
   localparam int K_W = $clog2(SEGMENTS + 1);
   localparam int PROD_W = LEN_W + K_W;
   localparam int SUM_W = LEN_W + 15;
   localparam int CMP_W = (LEN_W > salm_pkg::BUF_W) ? LEN_W : salm_pkg::BUF_W;
   localparam int LVL_W = salm_pkg::LEVEL_W;
   localparam int DEC_W = LVL_W + 2;
   localparam int RCP_SH = PROD_W + SEG_W;
   localparam int QP_W = 2 * PROD_W + 1;
   localparam longint unsigned RCP_M =
      ((64'd1 << RCP_SH) + 64'(SEGMENTS) - 64'd1) / 64'(SEGMENTS);

   logic [CMP_W-1:0]             raw_len;
   logic [CMP_W-1:0]             max_len;
   logic [LEN_W-1:0]             len_eff;
   logic [salm_pkg::MAG_W-1:0]   mag;
   logic                         restart;
   logic [POS_W-1:0]             pos_sel;

   logic [POS_W-1:0]             pos_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [POS_W-1:0]             ipos_ff;
   logic [LEN_W-1:0]             len_ff;
   logic [salm_pkg::MAG_W-1:0]   mag_ff;
   logic [PROD_W-1:0]            ps_ff;
   logic [K_W-1:0]               k_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [SEG_W-1:0]             seg_ff;
   logic [PROD_W-1:0]            prodseg_ff;
   logic [LEN_W-1:0]             seg_base_ff;

   logic [PROD_W-1:0]            ps_plus1;
   logic [PROD_W-1:0]            ps_plus2;
   logic                         hit;
   logic                         seg_start;
   logic [LEN_W-1:0]             next_pos;
   logic [LEN_W-1:0]             seg_count;
   logic [QP_W-1:0]              base_prod;

   logic [SUM_W-1:0]             div_dividend;
   logic [SUM_W-1:0]             div_divisor;
   logic                         div_busy;
   logic [SUM_W-1:0]             div_quotient;

   logic [LVL_W-1:0]             store_mem [SEGMENTS];
   logic [SEGMENTS-1:0]          store_valid_ff;
   logic [LVL_W-1:0]             old_ff;
   logic                         old_valid_ff;
   logic                         mem_read;
   logic [LVL_W-1:0]             old_level;
   logic [LVL_W-1:0]             mean_level;
   logic [LVL_W-1:0]             decay_level;
   logic [LVL_W-1:0]             new_level;

   logic                         rsp_valid_ff;
   logic [salm_pkg::INDEX_W-1:0] seg_out_ff;
   logic [LVL_W-1:0]             level_out_ff;

   // A zero length counts as one sample; longer buffers saturate.
   always_comb begin
      raw_len = CMP_W'(req_buffer_samples);
      max_len = CMP_W'(MAX_BUFFER);
      if (raw_len == '0) begin
         len_eff = LEN_W'(1);
      end else if (raw_len > max_len) begin
         len_eff = LEN_W'(max_len);
      end else begin
         len_eff = LEN_W'(raw_len);
      end
      if (req_sample[salm_pkg::SAMPLE_W-1]) begin
         mag = salm_pkg::MAG_W'(2 * salm_pkg::FULL_SCALE)
               - salm_pkg::MAG_W'($unsigned(req_sample));
      end else begin
         mag = salm_pkg::MAG_W'($unsigned(req_sample));
      end
      restart = LEN_W'(pos_ff) >= len_eff;
      pos_sel = restart ? '0 : pos_ff;
   end

   // Segment k starts at floor(k*len/SEGMENTS), so the comparisons are done on
   // products scaled by SEGMENTS and no division is needed during the search.
   // The start of the found segment comes from a reciprocal multiplication that
   // is exact for every product the search can reach.
   always_comb begin
      ps_plus1 = ps_ff + PROD_W'(SEGMENTS);
      ps_plus2 = ps_ff + PROD_W'(2 * SEGMENTS);
      hit = (k_ff < K_W'(SEGMENTS)) && (prod_ff < ps_plus1);
      seg_start = prodseg_ff >= ps_ff;
      next_pos = LEN_W'(ipos_ff) + LEN_W'(1);
      base_prod = QP_W'(prodseg_ff) * QP_W'(RCP_M);
      seg_count = next_pos - seg_base_ff;
      status.search_done = !hit;
      status.close = (prodseg_ff + PROD_W'(len_ff)) < ps_plus2;
      status.div_busy = div_busy;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.load) begin
         if (restart) begin
            sum_ff <= '0;
         end
      end else if (cmd.eval) begin
         if (seg_start) begin
            sum_ff <= SUM_W'(mag_ff);
         end else begin
            sum_ff <= sum_ff + SUM_W'(mag_ff);
         end
         if (next_pos == len_ff) begin
            pos_ff <= '0;
         end else begin
            pos_ff <= POS_W'(next_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ipos_ff <= pos_sel;
         len_ff <= len_eff;
         mag_ff <= mag;
         ps_ff <= PROD_W'(pos_sel) * PROD_W'(SEGMENTS);
         k_ff <= K_W'(1);
         prod_ff <= PROD_W'(len_eff);
         seg_ff <= '0;
         prodseg_ff <= '0;
      end else if (cmd.search_step && hit) begin
         seg_ff <= SEG_W'(k_ff);
         prodseg_ff <= prod_ff;
         k_ff <= k_ff + K_W'(1);
         prod_ff <= prod_ff + PROD_W'(len_ff);
      end else if (cmd.eval) begin
         seg_base_ff <= LEN_W'(base_prod >> RCP_SH);
      end
   end

   assign div_dividend = sum_ff;
   assign div_divisor = SUM_W'(seg_count);

   salm_div #(
      .WIDTH(SUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(div_dividend),
      .divisor(div_divisor),
      .busy(div_busy),
      .quotient(div_quotient)
   );

   assign mem_read = cmd.div_start && cmd.div_mean;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         store_mem[seg_ff] <= new_level;
      end
      if (mem_read) begin
         old_ff <= store_mem[seg_ff];
         old_valid_ff <= store_valid_ff[seg_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= '0;
      end else if (cmd.emit) begin
         store_valid_ff[seg_ff] <= 1'b1;
      end
   end

   always_comb begin
      old_level = old_valid_ff ? old_ff : '0;
      if (div_quotient > SUM_W'(salm_pkg::FULL_SCALE)) begin
         mean_level = LVL_W'(salm_pkg::FULL_SCALE);
      end else begin
         mean_level = LVL_W'(div_quotient);
      end
      decay_level = LVL_W'((DEC_W'(old_level) * DEC_W'(3)) >> 2);
      new_level = (decay_level > mean_level) ? decay_level : mean_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         seg_out_ff <= salm_pkg::INDEX_W'(seg_ff);
         level_out_ff <= new_level;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_segment_index = seg_out_ff;
   assign rsp_level = level_out_ff;

endmodule

@@ sv/salm_ctrl.sv @@
module salm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  salm_pkg::status_type status,
   output salm_pkg::cmd_type    cmd
);

   salm_pkg::state_type state_ff;
   salm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         salm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = salm_pkg::ST_SEARCH;
            end
         end
         salm_pkg::ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_done) begin
               state_in = salm_pkg::ST_EVAL;
            end
         end
         salm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.close ? salm_pkg::ST_DIVM_GO : salm_pkg::ST_IDLE;
         end
         salm_pkg::ST_DIVM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_mean = 1'b1;
            state_in = salm_pkg::ST_DIVM_WAIT;
         end
         salm_pkg::ST_DIVM_WAIT: begin
            cmd.div_mean = 1'b1;
            if (!status.div_busy) begin
               state_in = salm_pkg::ST_EMIT;
            end
         end
         salm_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = salm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/segmented_audio_level_meter_top.sv @@
// A sample that does not close its segment frees the input after the linear segment search
// and the evaluation step. A closing sample adds one pass of the bit-serial mean divider
// and then emits its result. A stalled result holds the block only at the next emit.
// Synchronous active-high reset clears position, sum, control and the level store.
module segmented_audio_level_meter_top #(
   parameter int SEGMENTS = 16,
   parameter int MAX_BUFFER = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [salm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [salm_pkg::BUF_W-1:0]           req_buffer_samples,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [salm_pkg::INDEX_W-1:0]         rsp_segment_index,
   output logic [salm_pkg::LEVEL_W-1:0]         rsp_level
);

   salm_pkg::cmd_type    cmd;
   salm_pkg::status_type status;

   salm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   salm_dp #(
      .SEGMENTS(SEGMENTS),
      .MAX_BUFFER(MAX_BUFFER)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_sample(req_sample),
      .req_buffer_samples(req_buffer_samples),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_segment_index(rsp_segment_index),
      .rsp_level(rsp_level)
   );

endmodule

@@ sv/salm_checker.sv @@
module salm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [salm_pkg::SAMPLE_W-1:0] req_sample,
   input logic [salm_pkg::BUF_W-1:0]           req_buffer_samples,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [salm_pkg::INDEX_W-1:0]         rsp_segment_index,
   input logic [salm_pkg::LEVEL_W-1:0]         rsp_level
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_index)
                                  && $stable(rsp_level))
   else $error("stalled result changed");

   // A stalled input transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample)
                                  && $stable(req_buffer_samples))
   else $error("stalled sample changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= 16'd32768)
   else $error("level above full scale");

   // Every sample needs at least the segment search before the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
   else $error("sample accepted on consecutive cycles");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("result valid after reset");

endmodule

bind segmented_audio_level_meter_top salm_checker u_salm_checker (.*);

@@ dv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEGMENTS = 16;
   localparam int MAX_BUFFER = 4096;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [salm_pkg::SAMPLE_W-1:0] sample;
      logic [salm_pkg::BUF_W-1:0]           length;
   } audio_item_type;

   typedef struct {
      logic [salm_pkg::INDEX_W-1:0] index;
      logic [salm_pkg::LEVEL_W-1:0] level;
   } level_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [salm_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [salm_pkg::BUF_W-1:0] req_buffer_samples = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [salm_pkg::INDEX_W-1:0] rsp_segment_index;
   logic [salm_pkg::LEVEL_W-1:0] rsp_level;

   audio_item_type sample_queue[$];
   level_report_type pending_levels[$];
   audio_item_type next_item;
   level_report_type seen;

   int unsigned meter_position = 0;
   longint unsigned meter_sum = 0;
   int unsigned meter_levels[SEGMENTS];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int fail_count = 0;
   int stall;

   segmented_audio_level_meter_top #(
      .SEGMENTS(SEGMENTS),
      .MAX_BUFFER(MAX_BUFFER)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_buffer_samples(req_buffer_samples),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_segment_index(rsp_segment_index),
      .rsp_level(rsp_level)
   );

   always #5 clock = ~clock;

   function automatic int unsigned segment_bound(input int unsigned k, input int unsigned len);
      return (k * len) / SEGMENTS;
   endfunction

   // Advances the level meter by one sample and queues the report it produces, if any.
   function automatic void update_levels(input logic signed [salm_pkg::SAMPLE_W-1:0] smp,
                                         input logic [salm_pkg::BUF_W-1:0] blen);
      int value;
      int unsigned len, mag, pos, seg, first, last, mean, decayed, updated;
      level_report_type report;
      len = blen;
      if (len == 0) begin
         len = 1;
      end
      if (len > MAX_BUFFER) begin
         len = MAX_BUFFER;
      end
      value = smp;
      mag = (value < 0) ? -value : value;
      pos = meter_position;
      if (pos >= len) begin
         pos = 0;
         meter_sum = 0;
      end
      seg = 0;
      for (int unsigned k = 1; k < SEGMENTS; k++) begin
         if (segment_bound(k, len) <= pos) begin
            seg = k;
         end
      end
      first = segment_bound(seg, len);
      last = segment_bound(seg + 1, len);
      if (pos == first) begin
         meter_sum = 0;
      end
      meter_sum += mag;
      if (pos + 1 == last) begin
         mean = 32'(meter_sum / (last - first));
         if (mean > salm_pkg::FULL_SCALE) begin
            mean = salm_pkg::FULL_SCALE;
         end
         decayed = (meter_levels[seg] * 3) >> 2;
         updated = (decayed > mean) ? decayed : mean;
         meter_levels[seg] = updated;
         report.index = seg[salm_pkg::INDEX_W-1:0];
         report.level = updated[salm_pkg::LEVEL_W-1:0];
         pending_levels.push_back(report);
      end
      pos++;
      if (pos >= len) begin
         pos = 0;
      end
      meter_position = pos;
   endfunction

   function automatic logic signed [salm_pkg::SAMPLE_W-1:0] pick_sample(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 511) - 256);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh8001;
               default: return 16'sh0000;
            endcase
         end
      endcase
   endfunction

   task automatic push_sample(input logic signed [salm_pkg::SAMPLE_W-1:0] smp,
                              input int len);
      audio_item_type item;
      item.sample = smp;
      item.length = len[salm_pkg::BUF_W-1:0];
      sample_queue.push_back(item);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (sample_queue.size() > 0) begin
            next_item = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_sample <= next_item.sample;
            req_buffer_samples <= next_item.length;
            if ($urandom_range(0, 39) == 0) begin
               req_burst = ~req_burst;
            end
            req_gap <= req_burst ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 29) == 0) begin
            rsp_burst = ~rsp_burst;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 4);
         rsp_ready <= (stall == 0);
         rsp_wait <= stall;
      end else if (rsp_wait > 0) begin
         rsp_ready <= (rsp_wait == 1);
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            update_levels(req_sample, req_buffer_samples);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_levels.size() == 0) begin
               $error("unexpected result transaction: segment_index %0d level %0d",
                      rsp_segment_index, rsp_level);
               fail_count++;
            end else begin
               seen = pending_levels.pop_front();
               if (rsp_segment_index !== seen.index) begin
                  $error("segment_index: expected %0d, actual %0d",
                         seen.index, rsp_segment_index);
                  fail_count++;
               end
               if (rsp_level !== seen.level) begin
                  $error("level: expected %0d, actual %0d", seen.level, rsp_level);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int count, len, cut, mode, pick;
      for (int i = 0; i < SEGMENTS; i++) begin
         meter_levels[i] = 0;
      end

      // Single-sample buffers close the last segment on every transaction.
      push_sample(16'sh8000, 1);
      push_sample(16'sh7fff, 1);
      push_sample(16'sh0000, 0);
      push_sample(16'sh0001, 1);
      // A two-sample buffer closes two segments and leaves the rest empty.
      push_sample(16'sh8000, 2);
      push_sample(16'sh7fff, 2);
      for (int i = 0; i < SEGMENTS; i++) begin
         push_sample((i % 2 == 0) ? 16'sh8000 : 16'sh0000 + 16'(i * 100), 16);
      end
      // Oversized length saturates, then the length shrinks mid-buffer.
      push_sample(16'sh7fff, 8191);
      push_sample(16'shffff, 3);
      push_sample(16'sh4000, 2);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         mode = $urandom_range(0, 2);
         if (pick == 0) begin
            push_sample(pick_sample(0), $urandom_range(0, 8191));
            count++;
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            cut = len;
            if (pick == 1 && len > 1) begin
               cut = $urandom_range(1, len - 1);
            end
            for (int i = 0; i < cut; i++) begin
               push_sample(pick_sample(mode), len);
            end
            count += cut;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_queue.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (pending_levels.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_levels.size() > 0) begin
         $error("%0d expected result transactions never arrived", pending_levels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
